### sv/multichannel_input_debounce_quantizer_defines.svh
// Assertion macros for the debounce quantizer.
// ASSERT_IMPLY: ante holds at an edge -> cons holds at the same edge.
// ASSERT_NEXT:  ante holds at an edge -> cons holds at the next edge.
`ifndef MULTICHANNEL_INPUT_DEBOUNCE_QUANTIZER_DEFINES_SVH
`define MULTICHANNEL_INPUT_DEBOUNCE_QUANTIZER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### sv/midq_pkg.sv
package midq_pkg;

  // widest sample the design supports; compares are done at this width
  localparam int MAX_SAMPLE_W = 16;
  localparam int CFG_W        = 32;
  localparam int TOL_W        = 10;
  localparam int LOW_W        = 8;

  typedef logic [2:0] level_t;
  typedef logic [MAX_SAMPLE_W-1:0] wide_t;

  typedef enum logic [1:0] {
    REG_BUTTON_MASK    = 2'd0,
    REG_TWO_LEVEL_MASK = 2'd1,
    REG_INVERTED_MASK  = 2'd2,
    REG_CHANGE_TOL     = 2'd3
  } cfg_reg_t;

  localparam logic [TOL_W-1:0] TOL_RESET = 10'd2;

  localparam wide_t THR_1 = 16'd200;
  localparam wide_t THR_2 = 16'd400;
  localparam wide_t THR_3 = 16'd600;
  localparam wide_t THR_4 = 16'd800;

  localparam level_t LVL_0 = 3'd0;
  localparam level_t LVL_1 = 3'd1;
  localparam level_t LVL_2 = 3'd2;
  localparam level_t LVL_3 = 3'd3;
  localparam level_t LVL_4 = 3'd4;

  // five-step level; inverted scale runs down from full scale
  function automatic level_t quantize(input wide_t r, input logic inv);
    level_t l;
    if (!inv) begin
      if (r < THR_1)      l = LVL_0;
      else if (r < THR_2) l = LVL_1;
      else if (r < THR_3) l = LVL_2;
      else if (r < THR_4) l = LVL_3;
      else                l = LVL_4;
    end else begin
      if (r > THR_4)      l = LVL_0;
      else if (r > THR_3) l = LVL_1;
      else if (r > THR_2) l = LVL_2;
      else if (r > THR_1) l = LVL_3;
      else                l = LVL_4;
    end
    return l;
  endfunction

endpackage

### sv/multichannel_input_debounce_quantizer.sv
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// input    | in_valid, in_stall, action, channel_id,   | in
//          | first_sample, second_sample               |
// output   | out_valid, out_stall, reading, reading_low,| out
//          | level, level_changed, reading_changed     |
// config   | cfg_write, cfg_index, cfg_data            | in
//
// One item per cycle while the sink does not stall; an accepted item is held in the input
// register, then written to the result register. The channel's stored reading/level entry
// is read, modified and written back between the input register and the result register.
// rst (synchronous) clears masks, tolerance (to 2), all stored entries and valids.
// in_stall rises only when the input register is full and the result register
// holds an item that the sink is stalling.
`include "multichannel_input_debounce_quantizer_defines.svh"

module multichannel_input_debounce_quantizer
  import midq_pkg::*;
#(
  parameter int CHANNELS    = 32,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  // input items
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   action,
  input  logic [4:0]             channel_id,
  input  logic [SAMPLE_BITS-1:0] first_sample,
  input  logic [SAMPLE_BITS-1:0] second_sample,
  // result items
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] reading,
  output logic [LOW_W-1:0]       reading_low,
  output level_t                 level,
  output logic                   level_changed,
  output logic                   reading_changed,
  // configuration writes
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [6:0] LAST_CH = 7'(CHANNELS - 1);
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

  // configuration registers
  logic [CFG_W-1:0] button_mask;
  logic [CFG_W-1:0] two_level_mask;
  logic [CFG_W-1:0] inverted_mask;
  logic [TOL_W-1:0] change_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_mask      <= '0;
      two_level_mask   <= '0;
      inverted_mask    <= '0;
      change_tolerance <= TOL_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_BUTTON_MASK:    button_mask      <= cfg_data;
        REG_TWO_LEVEL_MASK: two_level_mask   <= cfg_data;
        REG_INVERTED_MASK:  inverted_mask    <= cfg_data;
        REG_CHANGE_TOL:     change_tolerance <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------
  // Handshake: input register (s1) feeding the result register.
  // --------------------------------------------------------------------
  logic                   s1_valid;
  logic                   s1_action;
  logic [4:0]             s1_channel;
  logic [SAMPLE_BITS-1:0] s1_first;
  logic [SAMPLE_BITS-1:0] s1_second;

  logic advance;   // result register can take a new item
  logic move;      // s1 item is processed and written back this cycle
  logic in_accept;

  assign advance   = !out_valid || !out_stall;
  assign move      = s1_valid && advance;
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action  <= action;
      s1_channel <= channel_id;
      s1_first   <= first_sample;
      s1_second  <= second_sample;
    end
  end

  // --------------------------------------------------------------------
  // Per-channel state
  // --------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] readings [CHANNELS];
  level_t                 levels   [CHANNELS];

  // clamp channel to the last one; the clamped value always fits in 5 bits
  logic [6:0]      ch_ext;
  logic [6:0]      ch_clamp;
  logic [CH_W-1:0] ch_idx;
  logic [4:0]      ch_bit;

  assign ch_ext   = {2'b00, s1_channel};
  assign ch_clamp = (ch_ext > LAST_CH) ? LAST_CH : ch_ext;
  assign ch_idx   = CH_W'(ch_clamp);
  assign ch_bit   = ch_clamp[4:0];

  logic                   is_two;
  logic                   is_button;
  logic                   is_inv;
  logic [SAMPLE_BITS-1:0] old_r;
  level_t                 old_l;
  logic [SAMPLE_BITS-1:0] cand;     // value that would be stored
  logic [SAMPLE_BITS-1:0] confirm;  // second sample in the same domain
  logic                   debounce;
  logic                   take;
  logic [SAMPLE_BITS-1:0] new_r;
  level_t                 calc_l;
  level_t                 new_l;
  logic [SAMPLE_BITS-1:0] diff;
  logic [MAX_SAMPLE_W+1:0] r_ext;
  wide_t                  low_full;
  logic [LOW_W-1:0]       low_sat;
  logic                   r_changed;

  always_comb begin
    is_two    = two_level_mask[ch_bit];
    is_button = button_mask[ch_bit];
    is_inv    = inverted_mask[ch_bit];
    old_r     = readings[ch_idx];
    old_l     = levels[ch_idx];

    // two-level buttons see only zero or full scale
    if (is_two) begin
      cand     = (s1_first == '0)  ? '0 : FULL_SCALE;
      confirm  = (s1_second == '0) ? '0 : FULL_SCALE;
      debounce = 1'b1;
    end else begin
      cand     = s1_first;
      confirm  = s1_second;
      debounce = is_button;
    end

    // debounced: store only a new value confirmed by the second sample
    take  = !debounce || ((cand != old_r) && (confirm == cand));
    new_r = (s1_action && take) ? cand : old_r;

    if (is_two) begin
      calc_l = (new_r == '0) ? LVL_1 : LVL_0;   // pushed reads as zero
    end else begin
      calc_l = quantize(wide_t'(new_r), is_inv);
    end
    new_l = s1_action ? calc_l : old_l;

    diff      = (old_r > new_r) ? (old_r - new_r) : (new_r - old_r);
    r_changed = wide_t'(diff) > wide_t'(change_tolerance);

    r_ext    = (MAX_SAMPLE_W + 2)'(new_r);
    low_full = r_ext[MAX_SAMPLE_W+1:2];
    low_sat  = (low_full > wide_t'(8'hFF)) ? 8'hFF : low_full[LOW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        readings[i] <= '0;
        levels[i]   <= LVL_0;
      end
    end else if (move) begin
      readings[ch_idx] <= new_r;
      levels[ch_idx]   <= new_l;
    end
  end

  // --------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      reading         <= new_r;
      reading_low     <= low_sat;
      level           <= new_l;
      level_changed   <= (new_l != old_l);
      reading_changed <= r_changed;
    end
  end

  // --------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------
  `ASSERT_NEXT(a_report_no_flags, clk, rst, move && !s1_action, !level_changed && !reading_changed, "report-only item raised a change flag")
  `ASSERT_IMPLY(a_level_range, clk, rst, out_valid, level <= LVL_4, "level above top step")
  `ASSERT_NEXT(a_two_level_map, clk, rst, move && s1_action && is_two, level == ((reading == '0) ? LVL_1 : LVL_0), "two-level channel level disagrees with reading")

endmodule

### sim/conditioned_reading_check.sv
`timescale 1ns / 100ps

module conditioned_reading_check
  import midq_pkg::*;
#(
  parameter int CHANNELS    = 32,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   action,
  input  logic [4:0]             channel_id,
  input  logic [SAMPLE_BITS-1:0] first_sample,
  input  logic [SAMPLE_BITS-1:0] second_sample,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [SAMPLE_BITS-1:0] reading,
  input  logic [LOW_W-1:0]       reading_low,
  input  level_t                 level,
  input  logic                   level_changed,
  input  logic                   reading_changed,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output int                     fail_count,
  output int                     pending
);

  localparam int FULL_SCALE = 1023;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] reading;
    logic [LOW_W-1:0]       reading_low;
    level_t                 level;
    logic                   level_changed;
    logic                   reading_changed;
  } reading_item_t;

  logic [SAMPLE_BITS-1:0] chan_reading [CHANNELS];
  level_t                 chan_level   [CHANNELS];
  logic [CFG_W-1:0]       button_bits, two_level_bits, inverted_bits;
  logic [TOL_W-1:0]       tolerance;
  reading_item_t          expected_readings [$];
  reading_item_t          want, seen;

  function automatic level_t level_of(input int r, input bit inv);
    if (!inv)
      return (r < 200) ? LVL_0 : (r < 400) ? LVL_1 : (r < 600) ? LVL_2 :
             (r < 800) ? LVL_3 : LVL_4;
    return (r > 800) ? LVL_0 : (r > 600) ? LVL_1 : (r > 400) ? LVL_2 :
           (r > 200) ? LVL_3 : LVL_4;
  endfunction

  // updates the channel entry and returns the result the item should produce
  function automatic reading_item_t condition_channel(
      input logic act, input logic [4:0] id,
      input logic [SAMPLE_BITS-1:0] s1, input logic [SAMPLE_BITS-1:0] s2);
    int            ch, old_r, new_r, a, b, diff, low;
    bit            is_btn, is_two, is_inv;
    level_t        old_l;
    reading_item_t res;
    ch     = (int'(id) > CHANNELS - 1) ? CHANNELS - 1 : int'(id);
    is_btn = (ch < 32) ? button_bits[ch] : 1'b0;
    is_two = (ch < 32) ? two_level_bits[ch] : 1'b0;
    is_inv = (ch < 32) ? inverted_bits[ch] : 1'b0;
    old_r  = int'(chan_reading[ch]);
    old_l  = chan_level[ch];
    new_r  = old_r;
    if (act) begin
      if (is_two) begin
        a = (s1 == 0) ? 0 : FULL_SCALE;
        b = (s2 == 0) ? 0 : FULL_SCALE;
        if (a != old_r && b == a) new_r = a;
        chan_level[ch] = (new_r == 0) ? LVL_1 : LVL_0;
      end else begin
        if (!is_btn) new_r = int'(s1);
        else if (int'(s1) != old_r && s2 == s1) new_r = int'(s1);
        chan_level[ch] = level_of(new_r, is_inv);
      end
      chan_reading[ch] = new_r[SAMPLE_BITS-1:0];
    end
    diff = (old_r > new_r) ? old_r - new_r : new_r - old_r;
    low  = new_r >> 2;
    if (low > 255) low = 255;
    res.reading         = new_r[SAMPLE_BITS-1:0];
    res.reading_low     = low[LOW_W-1:0];
    res.level           = chan_level[ch];
    res.level_changed   = (chan_level[ch] != old_l);
    res.reading_changed = (diff > int'(tolerance));
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_reading[i] = '0;
        chan_level[i]   = LVL_0;
      end
      button_bits    = '0;
      two_level_bits = '0;
      inverted_bits  = '0;
      tolerance      = TOL_RESET;
      expected_readings.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{reading, reading_low, level, level_changed, reading_changed};
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none, got reading %0d",
                   $time, reading);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("reading", 32'(want.reading), 32'(seen.reading));
          check_field("reading_low", 32'(want.reading_low), 32'(seen.reading_low));
          check_field("level", 32'(want.level), 32'(seen.level));
          check_field("level_changed", 32'(want.level_changed),
                      32'(seen.level_changed));
          check_field("reading_changed", 32'(want.reading_changed),
                      32'(seen.reading_changed));
        end
      end
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_BUTTON_MASK:    button_bits    = cfg_data;
          REG_TWO_LEVEL_MASK: two_level_bits = cfg_data;
          REG_INVERTED_MASK:  inverted_bits  = cfg_data;
          REG_CHANGE_TOL:     tolerance      = cfg_data[TOL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_readings.push_back(
          condition_channel(action, channel_id, first_sample, second_sample));
    end
    pending = expected_readings.size();
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import midq_pkg::*;

  localparam int CHANNELS     = 32;
  localparam int SAMPLE_BITS  = 10;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 246;

  // all block inputs start at known values
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   action = 1'b0;
  logic [4:0]             channel_id = '0;
  logic [SAMPLE_BITS-1:0] first_sample = '0;
  logic [SAMPLE_BITS-1:0] second_sample = '0;
  logic                   out_stall = 1'b0;
  logic                   cfg_write = 1'b0;
  logic [1:0]             cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  logic                   in_stall;
  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] reading;
  logic [LOW_W-1:0]       reading_low;
  level_t                 level;
  logic                   level_changed;
  logic                   reading_changed;

  int fail_count;
  int pending;

  // steady modes switch off idling on one side; each flips halfway through a phase
  bit source_steady = 1'b0;
  bit sink_steady   = 1'b0;

  // last first_sample sent per channel, used to aim samples near the last sent value
  logic [SAMPLE_BITS-1:0] last_sample [CHANNELS];

  multichannel_input_debounce_quantizer #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (.*);

  conditioned_reading_check #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) reading_check (.*);

  always #5 clk = ~clk;

  // idle length: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // sink side: random stall runs, all driven at the falling edge
  initial begin : sink_stall
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (out_stall) begin
        out_stall = 1'b0;
        hold = $urandom_range(0, 6);
      end else begin
        hold = sink_steady ? 0 : gap_len();
        out_stall = (hold != 0);
        if (hold != 0) hold--;
      end
    end
  end

  // offer one item, hold it until taken; returns at the falling edge after
  // acceptance with valid still high (caller either sends again or drains)
  task automatic send_item(input logic act, input logic [4:0] ch,
                           input logic [SAMPLE_BITS-1:0] s1,
                           input logic [SAMPLE_BITS-1:0] s2);
    int gap;
    gap = source_steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    action        = act;
    channel_id    = ch;
    first_sample  = s1;
    second_sample = s2;
    last_sample[ch] = s1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering, then wait until every result is back and the two-stage
  // pipeline has emptied, before touching the registers
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] btn, input logic [CFG_W-1:0] two,
                            input logic [CFG_W-1:0] inv, input logic [TOL_W-1:0] tol);
    write_reg(REG_BUTTON_MASK, btn);
    write_reg(REG_TWO_LEVEL_MASK, two);
    write_reg(REG_INVERTED_MASK, inv);
    write_reg(REG_CHANGE_TOL, CFG_W'(tol));
  endtask

  // Random item. Most items apply samples; a good share of them are
  // confirmed pairs (second equals first) so button channels actually store,
  // and many first samples sit near a threshold or near the channel's last
  // value so tolerance and level boundaries get exercised.
  task automatic rand_item();
    logic                   act;
    logic [4:0]             ch;
    logic [SAMPLE_BITS-1:0] s1, s2;
    int                     v, pick;
    act = ($urandom_range(0, 9) != 0);
    ch  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 3)) :
                                        5'($urandom_range(0, 31));
    pick = $urandom_range(0, 9);
    case (pick)
      0: v = 0;
      1: v = 1023;
      2, 3: v = 200 * $urandom_range(1, 4) + $urandom_range(0, 2) - 1;
      4, 5, 6: begin
        v = int'(last_sample[ch]) + $urandom_range(0, 8) - 4;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
      end
      default: v = $urandom_range(0, 1023);
    endcase
    s1 = v[SAMPLE_BITS-1:0];
    pick = $urandom_range(0, 19);
    if (pick < 12) s2 = s1;
    else if (pick < 14) s2 = '0;
    else if (pick < 17) s2 = s1 ^ (SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1));
    else s2 = SAMPLE_BITS'($urandom_range(0, 1023));
    send_item(act, ch, s1, s2);
  endtask

  initial begin : stimulus
    for (int i = 0; i < CHANNELS; i++) last_sample[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, reset configuration: analog channels, tolerance 2.
    send_item(1'b0, 5'd0, 10'd1023, 10'd1023); // report only: samples ignored
    send_item(1'b1, 5'd0, 10'd0, 10'd1023);    // analog ignores second sample
    send_item(1'b1, 5'd0, 10'd1023, 10'd0);    // full scale, top level
    send_item(1'b1, 5'd0, 10'd1021, 10'd0);    // moved by tolerance: no flag
    send_item(1'b1, 5'd0, 10'd1018, 10'd0);    // moved by tolerance + 1
    send_item(1'b1, 5'd1, 10'd199, 10'd0);     // level boundaries
    send_item(1'b1, 5'd1, 10'd200, 10'd0);
    send_item(1'b1, 5'd1, 10'd599, 10'd0);
    send_item(1'b1, 5'd1, 10'd800, 10'd0);
    send_item(1'b1, 5'd31, 10'd777, 10'd777);  // last channel
    send_item(1'b0, 5'd31, 10'd0, 10'd0);
    drain();

    // ch2 button, ch3 two-level, ch4 inverted, ch5 all three bits set so
    // two-level wins; zero tolerance
    set_config(32'h0000_0024, 32'h0000_0028, 32'h0000_0030, 10'd0);
    send_item(1'b1, 5'd2, 10'd500, 10'd500);   // confirmed pair stores
    send_item(1'b1, 5'd2, 10'd500, 10'd500);   // same as stored: no change
    send_item(1'b1, 5'd2, 10'd700, 10'd701);   // failed debounce keeps reading
    send_item(1'b1, 5'd3, 10'd0, 10'd0);       // reset level 0 becomes pushed
    send_item(1'b1, 5'd3, 10'd5, 10'd1023);    // both map to full scale
    send_item(1'b1, 5'd3, 10'd7, 10'd0);       // mapped pair disagrees
    send_item(1'b1, 5'd4, 10'd801, 10'd0);     // inverted boundaries
    send_item(1'b1, 5'd4, 10'd800, 10'd0);
    send_item(1'b1, 5'd4, 10'd400, 10'd0);
    send_item(1'b1, 5'd4, 10'd200, 10'd0);
    send_item(1'b1, 5'd5, 10'd0, 10'd512);     // precedence, failed debounce
    send_item(1'b1, 5'd5, 10'd1, 10'd1);
    send_item(1'b0, 5'd4, 10'd1023, 10'd1023);
    send_item(1'b1, 5'd6, 10'd1, 10'd0);       // one-count move flags at tol 0
    drain();

    // Random phases, each under its own setting; the first two are extremes.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config('0, '0, '0, 10'd0);
        1: set_config('1, '1, '1, 10'd1023);
        2: set_config('1, '0, '1, 10'd2);
        3: set_config('1, '0, '0, TOL_W'($urandom_range(0, 8)));
        default: set_config($urandom, $urandom, $urandom,
                            TOL_W'($urandom_range(0, 1023)));
      endcase
      source_steady = ($urandom_range(0, 3) == 0);
      sink_steady   = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // short stretches without idling inside a phase too
        if (n == PHASE_ITEMS / 2) begin
          source_steady = ~source_steady;
          sink_steady   = ~sink_steady;
        end
        rand_item();
      end
      drain();
    end

    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
